// ===== sv/a2u_pkg.sv =====
// ----------------------------------------------------------------------------
// a2u_pkg
// Shared types and token tables for the accent escape to UTF-8 converter.
// ----------------------------------------------------------------------------
package a2u_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
    localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'

    // work for the emitter: up to four bytes, first byte in bytes[0]
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last;   // index of the final byte
        logic            eot;    // item carried end of text
    } t_job;

    // replacement looked up for a token
    typedef struct packed {
        logic        hit;
        logic [1:0]  last;       // number of utf-8 bytes minus one
        logic [23:0] seq;        // first byte in bits 23:16
    } t_repl;

    function automatic t_repl mk_repl(logic [1:0] last, logic [23:0] seq);
        t_repl r;
        r.hit  = 1'b1;
        r.last = last;
        r.seq  = seq;
        return r;
    endfunction

    // second character of any token
    function automatic logic tok_first(logic [7:0] c1);
        logic r;
        case (c1) inside
            ",", "C", "'", "^", 8'h60, ":", "e", "a", "~", "o", "O",
            "r", "s", "6", "9", "p", "0", "2", "3": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // three-byte tokens <x>
    function automatic t_repl tok_short(logic [7:0] c1);
        t_repl r;
        r = '0;
        unique case (c1)
            "e":     r = mk_repl(2'd2, 24'hE1B589);
            "a":     r = mk_repl(2'd2, 24'hE1B583);
            "o":     r = mk_repl(2'd2, 24'hE1B592);
            "r":     r = mk_repl(2'd1, 24'hCAB300);
            "0":     r = mk_repl(2'd1, 24'hC2B000);
            "2":     r = mk_repl(2'd1, 24'hC2B200);
            "3":     r = mk_repl(2'd1, 24'hC2B300);
            "9":     r = mk_repl(2'd0, 24'h270000);
            default: r = '0;
        endcase
        return r;
    endfunction

    // four-byte tokens <xy>
    function automatic t_repl tok_long(logic [7:0] c1, logic [7:0] c2);
        t_repl r;
        r = '0;
        unique case ({c1, c2})
            ",c":     r = mk_repl(2'd1, 24'hC3A700);
            ",C":     r = mk_repl(2'd1, 24'hC38700);
            "C=":     r = mk_repl(2'd2, 24'hE282AC);
            "'e":     r = mk_repl(2'd1, 24'hC3A900);
            "^e":     r = mk_repl(2'd1, 24'hC3AA00);
            16'h6065: r = mk_repl(2'd1, 24'hC3A800);
            ":e":     r = mk_repl(2'd1, 24'hC3AB00);
            "'E":     r = mk_repl(2'd1, 24'hC38900);
            16'h6045: r = mk_repl(2'd1, 24'hC38800);
            "^E":     r = mk_repl(2'd1, 24'hC38A00);
            ":E":     r = mk_repl(2'd1, 24'hC38B00);
            16'h6061: r = mk_repl(2'd1, 24'hC3A000);
            "'a":     r = mk_repl(2'd1, 24'hC3A100);
            "^a":     r = mk_repl(2'd1, 24'hC3A200);
            ":a":     r = mk_repl(2'd1, 24'hC3A400);
            ":A":     r = mk_repl(2'd1, 24'hC38400);
            "'A":     r = mk_repl(2'd1, 24'hC38100);
            16'h6041: r = mk_repl(2'd1, 24'hC38000);
            "~A":     r = mk_repl(2'd1, 24'hC38300);
            "^A":     r = mk_repl(2'd1, 24'hC38200);
            "'o":     r = mk_repl(2'd1, 24'hC3B300);
            "^o":     r = mk_repl(2'd1, 24'hC3B400);
            ":o":     r = mk_repl(2'd1, 24'hC3B600);
            16'h606F: r = mk_repl(2'd1, 24'hC3B200);
            "oe":     r = mk_repl(2'd1, 24'hC59300);
            ":O":     r = mk_repl(2'd1, 24'hC39600);
            "^O":     r = mk_repl(2'd1, 24'hC39400);
            "OE":     r = mk_repl(2'd1, 24'hC59200);
            "^i":     r = mk_repl(2'd1, 24'hC3AE00);
            "'i":     r = mk_repl(2'd1, 24'hC3AD00);
            16'h6069: r = mk_repl(2'd1, 24'hC3AC00);
            ":i":     r = mk_repl(2'd1, 24'hC3AF00);
            16'h6049: r = mk_repl(2'd1, 24'hC38C00);
            "'I":     r = mk_repl(2'd1, 24'hC38D00);
            16'h6075: r = mk_repl(2'd1, 24'hC3B900);
            "^u":     r = mk_repl(2'd1, 24'hC3BB00);
            ":u":     r = mk_repl(2'd1, 24'hC3BC00);
            "'u":     r = mk_repl(2'd1, 24'hC3BA00);
            ":U":     r = mk_repl(2'd1, 24'hC39C00);
            "'U":     r = mk_repl(2'd1, 24'hC39A00);
            16'h6055: r = mk_repl(2'd1, 24'hC39900);
            "^U":     r = mk_repl(2'd1, 24'hC39B00);
            "ss":     r = mk_repl(2'd1, 24'hC39F00);
            ",,":     r = mk_repl(2'd2, 24'hE2809E);
            "66":     r = mk_repl(2'd2, 24'hE2809D);
            "99":     r = mk_repl(2'd2, 24'hE2809C);
            "~n":     r = mk_repl(2'd1, 24'hC3B100);
            "~N":     r = mk_repl(2'd1, 24'hC39100);
            "^!":     r = mk_repl(2'd1, 24'hC2A100);
            "^?":     r = mk_repl(2'd1, 24'hC2BF00);
            "po":     r = mk_repl(2'd1, 24'hC2A300);
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/accent_escape_to_utf8.sv =====
// ----------------------------------------------------------------------------
// accent_escape_to_utf8
// Replaces <..> accent escape tokens in a byte stream with utf-8 sequences.
// ----------------------------------------------------------------------------
// the first byte for an item is written into the group queue when the item is
// accepted; bytes still held as a possible token wait for later items.
// throughput: one input byte per cycle while o_stall is low; the emitter
// sends one byte per accepted output item; the queue absorbs the difference.
// reset: synchronous, clears the held-byte count, the queue and the emitter.
module accent_escape_to_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_text_done
);

    a2u_pkg::t_job job, head;
    logic          push, full, pop, avail, take;

    assign take    = i_valid && !full;
    assign o_stall = full;

    a2u_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_job         (job)
    );

    a2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && take),
        .i_job   (job),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_head  (head)
    );

    a2u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (avail),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done)
    );

endmodule

// ===== sv/a2u_front.sv =====
// ----------------------------------------------------------------------------
// a2u_front
// Holds candidate token bytes, classifies each input byte and builds the
// byte group to emit for it.
// ----------------------------------------------------------------------------
module a2u_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_text_byte,
    input  logic            i_end_of_text,
    output logic            o_push,
    output a2u_pkg::t_job   o_job
);

    typedef enum logic [1:0] {
        K_PASS,
        K_HOLD,
        K_MATCH,
        K_FAIL
    } t_kind;

    logic [1:0]     r_cnt, n_cnt;
    logic [7:0]     r_c1, r_c2;
    t_kind          kind;
    a2u_pkg::t_repl repl;
    a2u_pkg::t_repl long_pre;
    a2u_pkg::t_repl short_hit;
    a2u_pkg::t_repl long_hit;
    logic           is_open, is_close;
    logic           inc_byte;
    logic [2:0]     raw_cnt;

    assign is_open   = (i_text_byte == a2u_pkg::CH_OPEN);
    assign is_close  = (i_text_byte == a2u_pkg::CH_CLOSE);
    assign short_hit = a2u_pkg::tok_short(r_c1);
    assign long_pre  = a2u_pkg::tok_long(r_c1, i_text_byte);
    assign long_hit  = a2u_pkg::tok_long(r_c1, r_c2);

    always_comb begin
        kind = K_FAIL;
        repl = short_hit;
        unique case (r_cnt)
            2'd0: begin
                kind = is_open ? K_HOLD : K_PASS;
            end
            2'd1: begin
                kind = a2u_pkg::tok_first(i_text_byte) ? K_HOLD : K_FAIL;
            end
            2'd2: begin
                if (is_close && short_hit.hit) begin
                    kind = K_MATCH;
                end else if (long_pre.hit) begin
                    kind = K_HOLD;
                end else begin
                    kind = K_FAIL;
                end
            end
            2'd3: begin
                repl = long_hit;
                kind = (is_close && long_hit.hit) ? K_MATCH : K_FAIL;
            end
            default: kind = K_FAIL;
        endcase
    end

    // raw group: held bytes then the new byte at position r_cnt
    always_comb begin
        inc_byte = 1'b1;
        n_cnt    = 2'd0;
        o_push   = 1'b1;
        case (kind)
            K_PASS:  n_cnt = 2'd0;
            K_MATCH: n_cnt = 2'd0;
            K_HOLD: begin
                o_push = i_end_of_text;
                n_cnt  = i_end_of_text ? 2'd0 : r_cnt + 2'd1;
            end
            default: begin
                // failed match: a new '<' starts over unless the text ends here
                inc_byte = !is_open || i_end_of_text;
                n_cnt    = (is_open && !i_end_of_text) ? 2'd1 : 2'd0;
            end
        endcase
        raw_cnt = {1'b0, r_cnt} + {2'b00, inc_byte};
    end

    always_comb begin
        o_job.eot = i_end_of_text;
        if (kind == K_MATCH) begin
            o_job.bytes[0] = repl.seq[23:16];
            o_job.bytes[1] = repl.seq[15:8];
            o_job.bytes[2] = repl.seq[7:0];
            o_job.bytes[3] = 8'h00;
            o_job.last     = repl.last;
        end else begin
            o_job.bytes[0] = (r_cnt == 2'd0) ? i_text_byte : a2u_pkg::CH_OPEN;
            o_job.bytes[1] = (r_cnt == 2'd1) ? i_text_byte : r_c1;
            o_job.bytes[2] = (r_cnt == 2'd2) ? i_text_byte : r_c2;
            o_job.bytes[3] = i_text_byte;
            o_job.last     = raw_cnt[1:0] - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_take) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && kind == K_HOLD) begin
            if (r_cnt == 2'd1) begin
                r_c1 <= i_text_byte;
            end
            if (r_cnt == 2'd2) begin
                r_c2 <= i_text_byte;
            end
        end
    end

endmodule

// ===== sv/a2u_queue.sv =====
// ----------------------------------------------------------------------------
// a2u_queue
// Small first-in first-out queue of byte groups between classifier and emitter.
// ----------------------------------------------------------------------------
module a2u_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  a2u_pkg::t_job   i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_avail,
    output a2u_pkg::t_job   o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    a2u_pkg::t_job  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== sv/a2u_back.sv =====
// ----------------------------------------------------------------------------
// a2u_back
// Emits the bytes of the queue head one per accepted output item.
// ----------------------------------------------------------------------------
module a2u_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  a2u_pkg::t_job   i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output logic            o_text_done
);

    logic [1:0] r_idx;
    logic       fire;

    assign o_valid     = i_avail;
    assign o_out_byte  = i_head.bytes[r_idx];
    assign o_run_last  = (r_idx == i_head.last);
    assign o_text_done = o_run_last && i_head.eot;
    assign fire        = o_valid && !i_stall;
    assign o_pop       = fire && o_run_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (fire) begin
            r_idx <= o_run_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

// ===== sv/a2u_checker.sv =====
// ----------------------------------------------------------------------------
// a2u_checker
// Port-level checks for the accent escape converter.
// ----------------------------------------------------------------------------
module a2u_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       i_end_of_text,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_text_done
);

    // text end is only flagged on the final byte of a group
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_text_done || o_run_last))
        else $error("text_done without run_last");

    // end of text always produces at least one byte
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_end_of_text) |=> o_valid)
        else $error("no output after end of text");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!o_valid && !o_stall))
        else $error("output or stall right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_byte)
            && $stable(o_run_last) && $stable(o_text_done)))
        else $error("stalled output item changed");

endmodule

bind accent_escape_to_utf8 a2u_checker u_a2u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_end_of_text (i_end_of_text),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_out_byte    (o_out_byte),
    .o_run_last    (o_run_last),
    .o_text_done   (o_text_done)
);
